/* design/rv32_pkg.sv */
// ----------------------------------------------------------------------------
// rv32_pkg
// shared types and constants for the rv32im execute unit
// ----------------------------------------------------------------------------
package rv32_pkg;

   localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
   localparam logic [31:0] SIGN32      = 32'h8000_0000;

   localparam logic [6:0] OP_IMM    = 7'b0010011;
   localparam logic [6:0] OP_REG    = 7'b0110011;
   localparam logic [6:0] OP_LUI    = 7'b0110111;
   localparam logic [6:0] OP_AUIPC  = 7'b0010111;
   localparam logic [6:0] OP_LOAD   = 7'b0000011;
   localparam logic [6:0] OP_STORE  = 7'b0100011;
   localparam logic [6:0] OP_JALR   = 7'b1100111;
   localparam logic [6:0] OP_JAL    = 7'b1101111;
   localparam logic [6:0] OP_BRANCH = 7'b1100011;

   localparam logic [6:0] F7_ZERO = 7'b0000000;
   localparam logic [6:0] F7_MUL  = 7'b0000001;
   localparam logic [6:0] F7_ALT  = 7'b0100000;

   localparam logic [2:0] ST_DONE    = 3'd0;
   localparam logic [2:0] ST_LOAD    = 3'd1;
   localparam logic [2:0] ST_HALT    = 3'd2;
   localparam logic [2:0] ST_UNSUP   = 3'd3;
   localparam logic [2:0] ST_BADRPLY = 3'd4;

   localparam logic [1:0] MK_NONE  = 2'd0;
   localparam logic [1:0] MK_READ  = 2'd1;
   localparam logic [1:0] MK_WRITE = 2'd2;

   localparam logic [0:0] CSR_RESET_PC = 1'b0;
   localparam logic [0:0] CSR_CONSOLE  = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DECODE,
      S_MDU,
      S_WRITE,
      S_OUT
   } state_type;

   typedef struct packed {
      logic       start;
      logic [2:0] funct3;
   } mdu_ctl_type;

endpackage

/* design/rv32_mdu.sv */
// ----------------------------------------------------------------------------
// rv32_mdu
// bit-serial multiply / divide unit, one bit per cycle
// ----------------------------------------------------------------------------
module rv32_mdu (
   input  logic               clock,
   input  logic               reset,
   input  rv32_pkg::mdu_ctl_type ctl,
   input  logic [31:0]        op_a,
   input  logic [31:0]        op_b,
   output logic               done,
   output logic [31:0]        result
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [2:0]  f3_ff, f3_in;
   logic [63:0] acc_ff, acc_in;      // mul: {hi,lo}; div: {rem,quo}
   logic [31:0] m_ff, m_in;          // multiplicand / divisor magnitude
   logic        neg_q_ff, neg_q_in, neg_r_ff, neg_r_in;
   logic [31:0] a_ff, a_in, b_ff, b_in;
   logic        done_ff, done_in;
   logic [31:0] res_ff, res_in;

   logic        is_div;
   logic [31:0] ma, mb;
   logic        sa, sb;
   logic [32:0] sum;
   logic [32:0] trial;
   logic [31:0] q, r;

   assign is_div = f3_ff[2];

   always_comb begin
      sa = 1'b0;
      sb = 1'b0;
      case (ctl.funct3)
         3'd1: begin sa = op_a[31]; sb = op_b[31]; end
         3'd2: begin sa = op_a[31]; end
         3'd4, 3'd6: begin sa = op_a[31]; sb = op_b[31]; end
         default: begin sa = 1'b0; sb = 1'b0; end
      endcase
      ma = sa ? 32'd0 - op_a : op_a;
      mb = sb ? 32'd0 - op_b : op_b;
   end

   always_comb begin
      sum   = {1'b0, acc_ff[63:32]} + (acc_ff[0] ? {1'b0, m_ff} : 33'd0);
      trial = {acc_ff[63:32], acc_ff[31]} - {1'b0, m_ff};
   end

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      f3_in    = f3_ff;
      acc_in   = acc_ff;
      m_in     = m_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      q        = 32'd0;
      r        = 32'd0;
      if (ctl.start) begin
         busy_in  = 1'b1;
         cnt_in   = 6'd0;
         f3_in    = ctl.funct3;
         m_in     = ctl.funct3[2] ? mb : ma;
         acc_in   = {32'd0, ctl.funct3[2] ? ma : mb};
         neg_q_in = sa ^ sb;
         neg_r_in = sa;
         a_in     = op_a;
         b_in     = op_b;
      end else if (busy_ff) begin
         if (cnt_ff != 6'd32) begin
            cnt_in = cnt_ff + 6'd1;
            if (is_div) begin
               if (!trial[32]) acc_in = {trial[31:0], acc_ff[30:0], 1'b1};
               else acc_in = {acc_ff[62:0], 1'b0};
            end else begin
               acc_in = {sum, acc_ff[31:1]};
            end
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            q = neg_q_ff ? 32'd0 - acc_ff[31:0] : acc_ff[31:0];
            r = neg_r_ff ? 32'd0 - acc_ff[63:32] : acc_ff[63:32];
            case (f3_ff)
               3'd0: res_in = acc_ff[31:0];
               3'd1, 3'd2: res_in = neg_q_ff ? ~acc_ff[63:32] + {31'd0, acc_ff[31:0] == 32'd0}
                                             : acc_ff[63:32];
               3'd3: res_in = acc_ff[63:32];
               3'd4, 3'd5: res_in = (b_ff == 32'd0) ? 32'hffff_ffff : q;
               default: res_in = (b_ff == 32'd0) ? a_ff : r;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      f3_ff    <= f3_in;
      acc_ff   <= acc_in;
      m_ff     <= m_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      res_ff   <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

/* design/rv32im_execute_unit.sv */
// ----------------------------------------------------------------------------
// rv32im_execute_unit
// multicycle rv32im core step: one item in, one result item out
// ----------------------------------------------------------------------------
// an item steps through read regs, decode/execute, write back and output
// a new item is taken only when idle; the input waits while a result is pending
// mul/div items also wait in the bit-serial mdu, one bit per cycle
// one item in flight at a time; the register file memory has one read port
// reset loads pc from reset_pc, clears flags and registers (a clearing pass zeroes every entry)
// items are not taken during the clearing pass
module rv32im_execute_unit #(
   parameter int REG_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_load_raw,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_instr_pc,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_write,
   output logic [4:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic [1:0]  rsp_mem_kind,
   output logic [31:0] rsp_mem_addr,
   output logic [2:0]  rsp_mem_bytes,
   output logic [31:0] rsp_store_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);

   // config registers
   logic [31:0] reset_pc_ff, console_ff;

   // architectural state
   logic [31:0] pc_ff, pc_in;
   logic        halted_ff, halted_in;
   logic        pend_ff, pend_in;
   logic [4:0]  pdest_ff, pdest_in;
   logic [2:0]  pwidth_ff, pwidth_in;

   // register file: memory, cleared by a sweep after reset
   logic [31:0] rf [32];
   logic [31:0] rs_a_ff, rs_b_ff;
   logic        clr_ff;
   logic [4:0]  clr_idx_ff;
   logic        rf_we;
   logic [4:0]  rf_wa;
   logic [31:0] rf_wd;

   rv32_pkg::state_type state_ff, state_in;

   // captured item
   logic        typ_ff;
   logic [31:0] inst_ff, raw_ff;

   // result record
   logic [2:0]  st_ff, st_in;
   logic [31:0] npc_ff, npc_in;
   logic        wr_ff, wr_in;
   logic [4:0]  widx_ff, widx_in;
   logic [31:0] wval_ff, wval_in;
   logic [1:0]  mk_ff, mk_in;
   logic [31:0] ma_ff, ma_in;
   logic [2:0]  mb_ff, mb_in;
   logic [31:0] sd_ff, sd_in;
   logic        use_mdu_in;
   logic [31:0] ipc_ff;

   // decode fields
   logic [6:0]  op, f7;
   logic [4:0]  rd, rs1, rs2;
   logic [2:0]  f3;
   logic [31:0] a, b, immi, imms, immb, immj, immu, v, addr, ldv;
   logic        ok, has_rd, take;
   logic [4:0]  sh;

   rv32_pkg::mdu_ctl_type mctl;
   logic        mdone;
   logic [31:0] mres;

   rv32_mdu u_mdu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mctl),
      .op_a   (rs_a_ff),
      .op_b   (rs_b_ff),
      .done   (mdone),
      .result (mres)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == rv32_pkg::S_IDLE) && !clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_pc_ff <= 32'h8000_0000;
         console_ff  <= 32'hA000_03F8;
      end else if (csr_valid) begin
         case (csr_index)
            rv32_pkg::CSR_RESET_PC: reset_pc_ff <= csr_data;
            rv32_pkg::CSR_CONSOLE:  console_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // register file port: one write, one read per cycle (operands read serially)
   always_ff @(posedge clock) begin
      if (rf_we) rf[rf_wa] <= rf_wd;
   end

   always_ff @(posedge clock) begin
      if (state_ff == rv32_pkg::S_IDLE) rs_a_ff <= rf[req_instr_word[19:15]];
      if (state_ff == rv32_pkg::S_READ) rs_b_ff <= rf[inst_ff[24:20]];
   end

   // operand fixups for x0 and registers beyond the count
   always_comb begin
      rs1 = inst_ff[19:15];
      rs2 = inst_ff[24:20];
      a   = (rs1 == 5'd0 || 32'(rs1) >= REG_COUNT) ? 32'd0 : rs_a_ff;
      b   = (rs2 == 5'd0 || 32'(rs2) >= REG_COUNT) ? 32'd0 : rs_b_ff;
   end

   always_comb begin
      op   = inst_ff[6:0];
      rd   = inst_ff[11:7];
      f3   = inst_ff[14:12];
      f7   = inst_ff[31:25];
      sh   = inst_ff[24:20];
      immi = {{20{inst_ff[31]}}, inst_ff[31:20]};
      imms = {{20{inst_ff[31]}}, inst_ff[31:25], inst_ff[11:7]};
      immb = {{19{inst_ff[31]}}, inst_ff[31], inst_ff[7], inst_ff[30:25],
              inst_ff[11:8], 1'b0};
      immj = {{11{inst_ff[31]}}, inst_ff[31], inst_ff[19:12], inst_ff[20],
              inst_ff[30:21], 1'b0};
      immu = {inst_ff[31:12], 12'd0};
   end

   always_comb begin
      case (pwidth_ff)
         3'd0: ldv = {{24{raw_ff[7]}}, raw_ff[7:0]};
         3'd1: ldv = {{16{raw_ff[15]}}, raw_ff[15:0]};
         3'd4: ldv = {24'd0, raw_ff[7:0]};
         3'd5: ldv = {16'd0, raw_ff[15:0]};
         default: ldv = raw_ff;
      endcase
   end

   // decode / execute of a captured item
   always_comb begin
      st_in  = rv32_pkg::ST_DONE;
      npc_in = pc_ff + 32'd4;
      wr_in  = 1'b0;
      widx_in = 5'd0;
      wval_in = 32'd0;
      mk_in  = rv32_pkg::MK_NONE;
      ma_in  = 32'd0;
      mb_in  = 3'd0;
      sd_in  = 32'd0;
      use_mdu_in = 1'b0;
      v      = 32'd0;
      ok     = 1'b1;
      has_rd = 1'b1;
      take   = 1'b0;
      addr   = a + immi;
      if (halted_ff) begin
         st_in = rv32_pkg::ST_HALT;
         npc_in = pc_ff;
      end else if (typ_ff) begin
         if (!pend_ff) begin
            st_in = rv32_pkg::ST_BADRPLY;
            npc_in = pc_ff;
         end else if (pdest_ff != 5'd0 && 32'(pdest_ff) < REG_COUNT) begin
            wr_in = 1'b1;
            widx_in = pdest_ff;
            wval_in = ldv;
         end
      end else if (pend_ff) begin
         st_in = rv32_pkg::ST_LOAD;
      end else if (inst_ff == rv32_pkg::EBREAK_WORD) begin
         st_in = rv32_pkg::ST_HALT;
         npc_in = pc_ff;
      end else begin
         case (op)
            rv32_pkg::OP_IMM: begin
               case (f3)
                  3'd0: v = a + immi;
                  3'd1: begin ok = (f7 == rv32_pkg::F7_ZERO); v = a << sh; end
                  3'd2: v = {31'd0, $signed(a) < $signed(immi)};
                  3'd3: v = {31'd0, a < immi};
                  3'd4: v = a ^ immi;
                  3'd5: begin
                     ok = (f7 == rv32_pkg::F7_ZERO) || (f7 == rv32_pkg::F7_ALT);
                     v = (f7 == rv32_pkg::F7_ALT) ? 32'($signed(a) >>> sh) : a >> sh;
                  end
                  3'd6: v = a | immi;
                  default: v = a & immi;
               endcase
            end
            rv32_pkg::OP_REG: begin
               if (f7 == rv32_pkg::F7_ZERO) begin
                  case (f3)
                     3'd0: v = a + b;
                     3'd1: v = a << b[4:0];
                     3'd2: v = {31'd0, $signed(a) < $signed(b)};
                     3'd3: v = {31'd0, a < b};
                     3'd4: v = a ^ b;
                     3'd5: v = a >> b[4:0];
                     3'd6: v = a | b;
                     default: v = a & b;
                  endcase
               end else if (f7 == rv32_pkg::F7_ALT && f3 == 3'd0) begin
                  v = a - b;
               end else if (f7 == rv32_pkg::F7_ALT && f3 == 3'd5) begin
                  v = 32'($signed(a) >>> b[4:0]);
               end else if (f7 == rv32_pkg::F7_MUL) begin
                  use_mdu_in = 1'b1;
               end else begin
                  ok = 1'b0;
               end
            end
            rv32_pkg::OP_LUI:   v = immu;
            rv32_pkg::OP_AUIPC: v = pc_ff + immu;
            rv32_pkg::OP_LOAD: begin
               if (f3 == 3'd3 || f3 > 3'd5) begin
                  ok = 1'b0;
               end else begin
                  has_rd = 1'b0;
                  st_in = rv32_pkg::ST_LOAD;
                  mk_in = rv32_pkg::MK_READ;
                  ma_in = addr;
                  mb_in = (f3[1:0] == 2'd0) ? 3'd1 : ((f3[1:0] == 2'd1) ? 3'd2 : 3'd4);
               end
            end
            rv32_pkg::OP_STORE: begin
               has_rd = 1'b0;
               if (f3 > 3'd2) begin
                  ok = 1'b0;
               end else if (a + imms != console_ff) begin
                  mk_in = rv32_pkg::MK_WRITE;
                  ma_in = a + imms;
                  sd_in = b;
                  mb_in = (f3 == 3'd0) ? 3'd1 : ((f3 == 3'd1) ? 3'd2 : 3'd4);
               end
            end
            rv32_pkg::OP_JALR: begin
               if (f3 != 3'd0) ok = 1'b0;
               v = pc_ff + 32'd4;
               npc_in = addr & ~32'd1;
            end
            rv32_pkg::OP_JAL: begin
               v = pc_ff + 32'd4;
               npc_in = pc_ff + immj;
            end
            rv32_pkg::OP_BRANCH: begin
               has_rd = 1'b0;
               case (f3)
                  3'd0: take = (a == b);
                  3'd1: take = (a != b);
                  3'd4: take = $signed(a) < $signed(b);
                  3'd5: take = !($signed(a) < $signed(b));
                  3'd6: take = a < b;
                  3'd7: take = a >= b;
                  default: ok = 1'b0;
               endcase
               if (take) npc_in = pc_ff + immb;
            end
            default: ok = 1'b0;
         endcase
         if (!ok) begin
            st_in = rv32_pkg::ST_UNSUP;
            npc_in = pc_ff;
            mk_in = rv32_pkg::MK_NONE;
            ma_in = 32'd0;
            mb_in = 3'd0;
            sd_in = 32'd0;
            use_mdu_in = 1'b0;
         end else if (has_rd && rd != 5'd0 && 32'(rd) < REG_COUNT) begin
            wr_in = 1'b1;
            widx_in = rd;
            wval_in = v;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rv32_pkg::S_IDLE:   if (req_valid && req_ready) state_in = rv32_pkg::S_READ;
         rv32_pkg::S_READ:   state_in = rv32_pkg::S_DECODE;
         rv32_pkg::S_DECODE: state_in = use_mdu_in ? rv32_pkg::S_MDU : rv32_pkg::S_WRITE;
         rv32_pkg::S_MDU:    if (mdone) state_in = rv32_pkg::S_WRITE;
         rv32_pkg::S_WRITE:  state_in = rv32_pkg::S_OUT;
         rv32_pkg::S_OUT:    if (rsp_ready) state_in = rv32_pkg::S_IDLE;
         default:            state_in = rv32_pkg::S_IDLE;
      endcase
   end

   // outputs and register file write control
   always_comb begin
      mctl.start  = (state_ff == rv32_pkg::S_DECODE) && use_mdu_in;
      mctl.funct3 = f3;
      rsp_valid   = (state_ff == rv32_pkg::S_OUT);
      rf_we = 1'b0;
      rf_wa = widx_ff;
      rf_wd = wval_ff;
      if (clr_ff) begin
         rf_we = 1'b1;
         rf_wa = clr_idx_ff;
         rf_wd = 32'd0;
      end else if (state_ff == rv32_pkg::S_WRITE && wr_ff) begin
         rf_we = 1'b1;
      end
   end

   // architectural update at write back
   always_comb begin
      pc_in     = pc_ff;
      halted_in = halted_ff;
      pend_in   = pend_ff;
      pdest_in  = pdest_ff;
      pwidth_in = pwidth_ff;
      if (state_ff == rv32_pkg::S_WRITE) begin
         if (st_ff == rv32_pkg::ST_HALT) halted_in = 1'b1;
         if (st_ff == rv32_pkg::ST_DONE) begin
            pc_in = npc_ff;
            pend_in = 1'b0;
         end
         if (mk_ff == rv32_pkg::MK_READ) begin
            pend_in   = 1'b1;
            pdest_in  = inst_ff[11:7];
            pwidth_in = inst_ff[14:12];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rv32_pkg::S_IDLE;
         pc_ff      <= reset_pc_ff;
         halted_ff  <= 1'b0;
         pend_ff    <= 1'b0;
         pdest_ff   <= 5'd0;
         pwidth_ff  <= 3'd0;
         clr_ff     <= 1'b1;
         clr_idx_ff <= 5'd0;
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         halted_ff <= halted_in;
         pend_ff   <= pend_in;
         pdest_ff  <= pdest_in;
         pwidth_ff <= pwidth_in;
         if (clr_ff) begin
            clr_idx_ff <= clr_idx_ff + 5'd1;
            if (clr_idx_ff == 5'd31) clr_ff <= 1'b0;
         end
      end
      if (req_valid && req_ready) begin
         typ_ff  <= req_type;
         inst_ff <= req_instr_word;
         raw_ff  <= req_load_raw;
      end
      if (state_ff == rv32_pkg::S_DECODE) begin
         st_ff   <= st_in;
         npc_ff  <= npc_in;
         wr_ff   <= wr_in;
         widx_ff <= widx_in;
         wval_ff <= wval_in;
         mk_ff   <= mk_in;
         ma_ff   <= ma_in;
         mb_ff   <= mb_in;
         sd_ff   <= sd_in;
      end else if (state_ff == rv32_pkg::S_MDU && mdone) begin
         wval_ff <= mres;
      end
   end

   assign rsp_status     = st_ff;
   assign rsp_instr_pc   = ipc_ff;
   assign rsp_next_pc    = npc_ff;
   assign rsp_reg_write  = wr_ff;
   assign rsp_reg_index  = widx_ff;
   assign rsp_reg_value  = wr_ff ? wval_ff : 32'd0;
   assign rsp_mem_kind   = mk_ff;
   assign rsp_mem_addr   = ma_ff;
   assign rsp_mem_bytes  = mb_ff;
   assign rsp_store_data = sd_ff;

   // pc moves at write back only for done items; instr_pc is the old value
   always_ff @(posedge clock) begin
      if (state_ff == rv32_pkg::S_DECODE) ipc_ff <= pc_ff;
   end

   // no item accepted while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item accepted with result pending");

   // mdu completes only while waiting for it
   assert property (@(posedge clock) disable iff (reset)
      mdone |-> state_ff == rv32_pkg::S_MDU)
      else $error("mdu done outside wait");

   // no items during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req_ready)
      else $error("item accepted during clear");

endmodule
